FILE: sv/srsg_pkg.sv
`default_nettype none

package srsg_pkg;

    // field widths
    localparam int W_W = 31;   // raw word
    localparam int S_W = 16;   // sample and max_value
    localparam int Z_W = 20;   // probability as Q.20
    localparam int Q_W = 25;   // 2 ln(1/z) in Q.20
    localparam int T_W = 23;   // t in Q3.20
    localparam int X_W = 25;   // signed deviate in Q.20

    typedef logic [Q_W-1:0]        t_q;
    typedef logic [T_W-1:0]        t_t;
    typedef logic signed [X_W-1:0] t_x;

    // register indexes
    localparam logic CFG_MAX  = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // shape modes
    localparam logic [1:0] MODE_UNIFORM = 2'd0;
    localparam logic [1:0] MODE_NORMAL  = 2'd1;
    localparam logic [1:0] MODE_POS     = 2'd2;
    localparam logic [1:0] MODE_NEG     = 2'd3;

    // stage counts of the sections
    localparam int LAT_FRONT = 4;
    localparam int LAT_LOG   = 24;
    localparam int LAT_SQRT  = T_W;
    localparam int LAT_POLY  = 27;
    localparam int LAT_UMOD  = W_W;
    localparam int LAT_DEV   = LAT_FRONT + LAT_LOG + LAT_SQRT + LAT_POLY;
    localparam int LAT_SCALE = 4;
    localparam int LAT_TOT   = LAT_DEV + LAT_SCALE;

    // Q.20 coefficients
    localparam logic [21:0] C0_Q20    = 22'd2637711;
    localparam logic [19:0] C1_Q20    = 20'd841852;
    localparam logic [13:0] C2_Q20    = 14'd10830;
    localparam logic [20:0] D1_Q20    = 21'd1502387;
    localparam logic [17:0] D2_Q20    = 18'd198463;
    localparam logic [10:0] D3_Q20    = 11'd1372;
    localparam logic [20:0] LN2X2_Q20 = 21'd1453635;

    // reciprocals: floor(w/1e6), floor(zr*2^20/1e6), floor(a/167), floor(a/34)
    localparam logic [31:0] RCP_MEG = 32'd2251799814;
    localparam logic [34:0] RCP_Z20 = 35'd18014398510;
    localparam logic [20:0] RCP_167 = 21'd1607398;
    localparam logic [20:0] RCP_34  = 21'd1973791;
    localparam logic [19:0] MEG     = 20'd1000000;
    localparam logic [19:0] HALF_MEG = 20'd500000;

endpackage

`default_nettype wire

FILE: sv/srsg_word_if.sv
`default_nettype none

interface srsg_word_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

FILE: sv/srsg_sample_if.sv
`default_nettype none

interface srsg_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: sv/shaped_random_sample_generator.sv
// Pipeline: 82 register stages from the accepted word to the output sample register.
// Throughput: one word per cycle; all stages advance together and hold while
// the output register holds an untaken sample.
// The deviate path is 78 stages (reciprocal mod, 20 squarings, 23 root bits,
// 22 quotient bits); uniform mode runs a 31-stage remainder divider beside it.
// Reset (synchronous, active low) clears the valid bits and sets max_value 255, mode 0.
`default_nettype none

module shaped_random_sample_generator #(
    parameter int OUT_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    srsg_word_if.sink         i_word,
    srsg_sample_if.source     o_sample,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);
    import srsg_pkg::*;

    localparam int KEEP_W = (OUT_BITS < S_W) ? OUT_BITS : S_W;
    localparam logic [S_W-1:0] SAMPLE_MASK = S_W'((33'd1 << KEEP_W) - 33'd1);

    // configuration
    logic [S_W-1:0] r_max;
    logic [1:0]     r_mode;
    logic [11:0]    r_sig_n;
    logic [14:0]    r_sig_s;
    logic [19:0]    w_a;
    logic [40:0]    w_pn;
    logic [40:0]    w_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= 16'd255;
            r_mode <= MODE_UNIFORM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX:  r_max  <= i_cfg_data;
                CFG_MODE: r_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sigma = floor((max+1)*10/167) and floor((max+1)*10/34)
    assign w_a  = (20'(r_max) + 20'd1) * 20'd10;
    assign w_pn = 41'(w_a) * 41'(RCP_167);
    assign w_ps = 41'(w_a) * 41'(RCP_34);

    always_ff @(posedge i_clk) begin
        r_sig_n <= w_pn[39:28];
        r_sig_s <= w_ps[40:26];
    end

    // pipeline control
    logic               w_en;
    logic [LAT_TOT-1:0] r_vld;

    assign w_en         = !r_vld[LAT_TOT-1] || o_sample.ready;
    assign i_word.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT_TOT-2:0], i_word.valid};
        end
    end

    // deviate path
    logic [Z_W-1:0] w_z20;
    logic           w_up4;
    t_q             w_q;
    t_t             w_t;
    t_x             w_x;
    logic           w_up;
    logic [S_W-1:0] w_um;
    logic [S_W-1:0] w_um_d;

    srsg_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_word  (i_word.random_word),
        .o_z20   (w_z20),
        .o_upper (w_up4)
    );

    srsg_log u_log (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_z20 (w_z20),
        .o_q   (w_q)
    );

    srsg_sqrt u_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_q   (w_q),
        .o_t   (w_t)
    );

    srsg_poly u_poly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (w_t),
        .o_x   (w_x)
    );

    srsg_delay #(
        .WIDTH (1),
        .DEPTH (LAT_DEV - LAT_FRONT)
    ) u_up_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_up4),
        .o_q   (w_up)
    );

    // uniform path
    srsg_umod u_umod (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_word (i_word.random_word),
        .i_max  (r_max),
        .o_rem  (w_um)
    );

    srsg_delay #(
        .WIDTH (S_W),
        .DEPTH (LAT_DEV - LAT_UMOD)
    ) u_um_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_um),
        .o_q   (w_um_d)
    );

    // scale, clamp and fold
    t_x                  r_xs;
    logic signed [40:0]  r_prod;
    logic signed [41:0]  r_v;
    logic [S_W-1:0]      r_um1, r_um2, r_um3;
    logic [S_W-1:0]      r_sample;
    logic [14:0]         w_sig;
    logic [16:0]         w_half;
    logic signed [41:0]  w_base;
    logic signed [41:0]  w_mxf;
    logic signed [41:0]  w_mx2f;
    logic signed [41:0]  n_w;
    logic [S_W-1:0]      n_res;

    assign w_sig  = (r_mode == MODE_NORMAL) ? {3'b0, r_sig_n} : r_sig_s;
    assign w_half = ({1'b0, r_max} + 17'd1) >> 1;
    assign w_mxf  = $signed({6'b0, r_max, 20'b0});
    assign w_mx2f = $signed({5'b0, r_max, 21'b0});

    always_comb begin
        case (r_mode)
            MODE_NORMAL: w_base = $signed({6'b0, w_half[15:0], 20'b0});
            MODE_NEG:    w_base = w_mxf;
            default:     w_base = '0;
        endcase
    end

    always_comb begin
        n_w   = r_v;
        n_res = r_um3;
        case (r_mode)
            MODE_UNIFORM: n_res = r_um3;
            MODE_NORMAL: begin
                if (r_v > w_mxf) begin
                    n_w = w_mxf;
                end else if (r_v < 0) begin
                    n_w = '0;
                end
                n_res = n_w[35:20];
            end
            MODE_POS: begin
                if (r_v > w_mxf) begin
                    n_w = w_mxf;
                end else if (r_v < -w_mxf) begin
                    n_w = -w_mxf;
                end
                if (n_w < 0) begin
                    n_w = -n_w;
                end
                n_res = n_w[35:20];
            end
            MODE_NEG: begin
                if (r_v > w_mx2f) begin
                    n_w = w_mx2f;
                end else if (r_v < 0) begin
                    n_w = '0;
                end
                // fold the top half back below max
                if (n_w > w_mxf) begin
                    n_w = w_mx2f - n_w;
                end
                n_res = n_w[35:20];
            end
            default: n_res = r_um3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xs     <= w_up ? -w_x : w_x;
            r_um1    <= w_um_d;
            r_prod   <= $signed({1'b0, w_sig}) * r_xs;
            r_um2    <= r_um1;
            r_v      <= w_base + $signed({r_prod[40], r_prod});
            r_um3    <= r_um2;
            r_sample <= n_res & SAMPLE_MASK;
        end
    end

    assign o_sample.valid  = r_vld[LAT_TOT-1];
    assign o_sample.sample = r_sample;

    // a stalled pipeline keeps its valid bits
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // an accepted word enters the first stage
    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && i_word.valid) |=> r_vld[0])
        else $error("accepted word lost at entry");

    // no word enters when none is offered
    a_no_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !i_word.valid) |=> !r_vld[0])
        else $error("word invented at entry");

endmodule

`default_nettype wire

FILE: sv/srsg_delay.sv
`default_nettype none

module srsg_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_line [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];
endmodule

`default_nettype wire

FILE: sv/srsg_umod.sv
`default_nettype none

// word mod (max_value + 1), one word bit per stage
module srsg_umod (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [srsg_pkg::W_W-1:0] i_word,
    input  wire logic [srsg_pkg::S_W-1:0] i_max,
    output logic      [srsg_pkg::S_W-1:0] o_rem
);
    import srsg_pkg::*;

    logic [S_W:0]   w_div;
    logic [S_W-1:0] r_rem  [0:W_W-1];
    logic [W_W-1:0] r_word [0:W_W-2];

    assign w_div = {1'b0, i_max} + {{S_W{1'b0}}, 1'b1};

    for (genvar k = 0; k < W_W; k++) begin : g_step
        localparam int B = W_W - 1 - k;
        logic [S_W-1:0] rem_in;
        logic [W_W-1:0] word_in;
        logic [S_W:0]   pre;
        logic [S_W:0]   dif;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign word_in = i_word;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign word_in = r_word[k-1];
        end

        assign pre = {rem_in, word_in[B]};
        assign dif = pre - w_div;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= (pre >= w_div) ? dif[S_W-1:0] : pre[S_W-1:0];
            end
        end

        if (k < W_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_word[k] <= word_in;
                end
            end
        end
    end

    assign o_rem = r_rem[W_W-1];
endmodule

`default_nettype wire

FILE: sv/srsg_front.sv
`default_nettype none

// word -> folded probability z in Q.20 and the upper-half flag
module srsg_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [srsg_pkg::W_W-1:0] i_word,
    output logic      [srsg_pkg::Z_W-1:0] o_z20,
    output logic                          o_upper
);
    import srsg_pkg::*;

    logic [W_W-1:0] r_w1;
    logic [62:0]    r_p1;
    logic [19:0]    r_r2;
    logic [18:0]    r_zr3;
    logic           r_up3;
    logic [Z_W-1:0] r_z4;
    logic           r_up4;

    logic [62:0] w_p1;
    logic [31:0] w_qm;
    logic [31:0] w_r;
    logic [19:0] w_zr;
    logic [53:0] w_pz;

    assign w_p1 = 63'(i_word) * 63'(RCP_MEG);
    assign w_qm = 32'(r_p1[62:51]) * 32'(MEG);
    assign w_r  = 32'(r_w1) - w_qm;

    always_comb begin
        w_zr = (r_r2 >= HALF_MEG) ? (MEG - r_r2) : r_r2;
        if (w_zr == '0) begin
            w_zr = 20'd1;
        end
    end

    assign w_pz = 54'(r_zr3) * 54'(RCP_Z20);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1  <= i_word;
            r_p1  <= w_p1;
            r_r2  <= w_r[19:0];
            r_zr3 <= w_zr[18:0];
            r_up3 <= (r_r2 >= HALF_MEG);
            r_z4  <= w_pz[53:34];
            r_up4 <= r_up3;
        end
    end

    assign o_z20   = r_z4;
    assign o_upper = r_up4;
endmodule

`default_nettype wire

FILE: sv/srsg_log.sv
`default_nettype none

// q = 2 ln(1/z) via -log2 by repeated squaring, one squaring per stage
module srsg_log (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [srsg_pkg::Z_W-1:0] i_z20,
    output srsg_pkg::t_q                  o_q
);
    import srsg_pkg::*;

    localparam int STEPS = 20;

    logic [Z_W-1:0] r_z;
    logic [4:0]     r_sh;
    logic [4:0]     n_sh;
    logic [20:0]    r_m    [0:STEPS];
    logic [19:0]    r_frac [0:STEPS];
    logic [4:0]     r_shc  [0:STEPS];
    logic [24:0]    r_nl;
    t_q             r_q;

    logic [40:0] w_shl;
    logic [45:0] w_pq;

    // leading one gives the integer part of -log2
    always_comb begin
        n_sh = 5'd20;
        for (int b = 0; b < Z_W; b++) begin
            if (i_z20[b]) begin
                n_sh = 5'(20 - b);
            end
        end
    end

    assign w_shl = {21'b0, r_z} << r_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z       <= i_z20;
            r_sh      <= n_sh;
            r_m[0]    <= w_shl[20:0];
            r_frac[0] <= '0;
            r_shc[0]  <= r_sh;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_sq
        logic [41:0] mm;
        logic [19:0] frac;

        assign mm = 42'(r_m[k]) * 42'(r_m[k]);

        always_comb begin
            frac = r_frac[k];
            frac[STEPS-1-k] = mm[41];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k+1]    <= mm[41] ? mm[41:21] : mm[40:20];
                r_frac[k+1] <= frac;
                r_shc[k+1]  <= r_shc[k];
            end
        end
    end

    assign w_pq = 46'(r_nl) * 46'(LN2X2_Q20);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nl <= {r_shc[STEPS], 20'b0} - {5'b0, r_frac[STEPS]};
            r_q  <= w_pq[44:20];
        end
    end

    assign o_q = r_q;
endmodule

`default_nettype wire

FILE: sv/srsg_sqrt.sv
`default_nettype none

// t = floor(sqrt(q * 2^20)), one root bit per stage
module srsg_sqrt (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire srsg_pkg::t_q i_q,
    output srsg_pkg::t_t      o_t
);
    import srsg_pkg::*;

    localparam int REM_W = T_W + 3;

    logic [REM_W-1:0] r_rem  [0:T_W-2];
    t_q               r_qc   [0:T_W-2];
    t_t               r_root [0:T_W-1];

    for (genvar k = 0; k < T_W; k++) begin : g_bit
        localparam int J = T_W - 1 - k;
        logic [REM_W-1:0] rem_in;
        t_t               root_in;
        t_q               q_in;
        logic [2*T_W-1:0] v;
        logic [REM_W-1:0] pre;
        logic [REM_W-1:0] trial;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign q_in    = i_q;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign q_in    = r_qc[k-1];
        end

        assign v     = {{(2*T_W-Q_W-20){1'b0}}, q_in, 20'b0};
        assign pre   = {rem_in[REM_W-3:0], v[2*J+1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = (pre >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= {root_in[T_W-2:0], take};
            end
        end

        if (k < T_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? (pre - trial) : pre;
                    r_qc[k]  <= q_in;
                end
            end
        end
    end

    assign o_t = r_root[T_W-1];
endmodule

`default_nettype wire

FILE: sv/srsg_poly.sv
`default_nettype none

// rational correction x = t - num/den; products, then one quotient bit per stage
module srsg_poly (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire srsg_pkg::t_t i_t,
    output srsg_pkg::t_x      o_x
);
    import srsg_pkg::*;

    localparam int NUM_W  = 24;
    localparam int DEN_W  = 25;
    localparam int DREM_W = DEN_W + 1;
    localparam int QB     = 22;

    // products
    t_t          r_t1, r_t2, r_t3, r_t4;
    logic [24:0] r_tsq;
    logic [22:0] r_c1t, r_c1t2;
    logic [23:0] r_d1t, r_d1t2;
    logic [27:0] r_tcu;
    logic [18:0] r_c2t2;
    logic [22:0] r_d2t2;
    logic [18:0] r_d3t3;
    logic [NUM_W-1:0] r_num3, r_num4;
    logic [DEN_W-1:0] r_dp3, r_den4;

    logic [45:0] w_tt;
    logic [42:0] w_c1;
    logic [43:0] w_d1;
    logic [47:0] w_t3;
    logic [38:0] w_c2;
    logic [42:0] w_d2;
    logic [38:0] w_d3;

    assign w_tt = 46'(i_t) * 46'(i_t);
    assign w_c1 = 43'(i_t) * 43'(C1_Q20);
    assign w_d1 = 44'(i_t) * 44'(D1_Q20);
    assign w_t3 = 48'(r_tsq) * 48'(r_t1);
    assign w_c2 = 39'(r_tsq) * 39'(C2_Q20);
    assign w_d2 = 43'(r_tsq) * 43'(D2_Q20);
    assign w_d3 = 39'(r_tcu) * 39'(D3_Q20);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1   <= i_t;
            r_tsq  <= w_tt[44:20];
            r_c1t  <= w_c1[42:20];
            r_d1t  <= w_d1[43:20];

            r_t2   <= r_t1;
            r_tcu  <= w_t3[47:20];
            r_c2t2 <= w_c2[38:20];
            r_d2t2 <= w_d2[42:20];
            r_c1t2 <= r_c1t;
            r_d1t2 <= r_d1t;

            r_t3   <= r_t2;
            r_d3t3 <= w_d3[38:20];
            r_num3 <= NUM_W'(C0_Q20) + NUM_W'(r_c1t2) + NUM_W'(r_c2t2);
            r_dp3  <= DEN_W'(1 << 20) + DEN_W'(r_d1t2) + DEN_W'(r_d2t2);

            r_t4   <= r_t3;
            r_num4 <= r_num3;
            r_den4 <= r_dp3 + DEN_W'(r_d3t3);
        end
    end

    // ratio = floor(num * 2^20 / den); num/den stays below 4
    logic [DREM_W-1:0] r_drem [0:QB-2];
    logic [NUM_W-1:0]  r_dnum [0:QB-2];
    logic [DEN_W-1:0]  r_dden [0:QB-2];
    logic [QB-1:0]     r_quo  [0:QB-1];
    t_t                r_dt   [0:QB-1];
    t_x                r_x;

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int B = QB - 1 - k;
        logic [DREM_W-1:0] rem_in;
        logic [NUM_W-1:0]  num_in;
        logic [DEN_W-1:0]  den_in;
        logic [QB-1:0]     quo_in;
        t_t                t_in;
        logic              nbit;
        logic [DREM_W-1:0] pre;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in = {{(DREM_W-NUM_W+2){1'b0}}, r_num4[NUM_W-1:2]};
            assign num_in = r_num4;
            assign den_in = r_den4;
            assign quo_in = '0;
            assign t_in   = r_t4;
        end else begin : g_next
            assign rem_in = r_drem[k-1];
            assign num_in = r_dnum[k-1];
            assign den_in = r_dden[k-1];
            assign quo_in = r_quo[k-1];
            assign t_in   = r_dt[k-1];
        end

        if (B >= 20) begin : g_nb
            assign nbit = num_in[B-20];
        end else begin : g_zb
            assign nbit = 1'b0;
        end

        assign pre  = {rem_in[DREM_W-2:0], nbit};
        assign take = (pre >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_in[QB-2:0], take};
                r_dt[k]  <= t_in;
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_drem[k] <= take ? (pre - {1'b0, den_in}) : pre;
                    r_dnum[k] <= num_in;
                    r_dden[k] <= den_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= $signed({2'b0, r_dt[QB-1]}) - $signed({3'b0, r_quo[QB-1]});
        end
    end

    assign o_x = r_x;
endmodule

`default_nettype wire

FILE: sim/shaped_random_sample_generator_test.sv
`default_nettype none

module shaped_random_sample_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srsg_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [15:0] i_cfg_data;

    srsg_word_if   word_ch ();
    srsg_sample_if sample_ch ();

    shaped_random_sample_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (word_ch.sink),
        .o_sample   (sample_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the registers
    logic [15:0] cur_max;
    logic [1:0]  cur_mode;

    logic [30:0] pending_words[$];
    logic [15:0] expected_samples[$];

    int errors = 0;
    int samples_seen = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    bit [3:0] modes_hit = 0;
    bit word_taken = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] neg_log2(input logic [31:0] z20);
        int unsigned e;
        logic [63:0] m, frac, bitv;
        e = 0;
        frac = 0;
        bitv = 64'd1 << 19;
        while (e < 31 && (z20 >> (e + 1)) != 0)
            e++;
        m = 64'(z20) << (20 - e);
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 20;
            if (m >= (64'd1 << 21)) begin
                m = m >> 1;
                frac |= bitv;
            end
            bitv = bitv >> 1;
        end
        return (64'(20 - e) << 20) - frac;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v)
            one = one >> 2;
        while (one != 0) begin
            if (v >= res + one) begin
                v = v - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic longint gauss_deviate(input logic [30:0] w);
        longint unsigned r, zr, z20, nl, q, t, t2, t3;
        longint num, den, ratio, x;
        bit upper;
        r = w % 1000000;
        upper = r >= 500000;
        zr = upper ? 1000000 - r : r;
        if (zr == 0)
            zr = 1;
        z20 = (zr << 20) / 1000000;
        if (z20 == 0)
            z20 = 1;
        nl = neg_log2(z20[31:0]);
        q = (nl * 1453635) >> 20;
        t = int_sqrt(q << 20);
        t2 = (t * t) >> 20;
        t3 = (t2 * t) >> 20;
        num = longint'(C0_Q20) + longint'((longint'(C1_Q20) * t) >> 20)
            + longint'((longint'(C2_Q20) * t2) >> 20);
        den = 64'sd1048576 + longint'((longint'(D1_Q20) * t) >> 20)
            + longint'((longint'(D2_Q20) * t2) >> 20)
            + longint'((longint'(D3_Q20) * t3) >> 20);
        ratio = (num * 1048576) / den;
        x = longint'(t) - ratio;
        return upper ? -x : x;
    endfunction

    function automatic logic [15:0] shape_sample(input logic [30:0] w);
        longint mx, x, v, sigma, one;
        one = 1048576;
        mx = longint'(cur_max);
        if (cur_mode == MODE_UNIFORM)
            return 16'(longint'(w) % (mx + 1));
        x = gauss_deviate(w);
        if (cur_mode == MODE_NORMAL) begin
            sigma = ((mx + 1) * 10) / 167;
            v = ((mx + 1) / 2) * one + sigma * x;
            if (v > mx * one)
                v = mx * one;
            else if (v < 0)
                v = 0;
        end else if (cur_mode == MODE_POS) begin
            sigma = ((mx + 1) * 10) / 34;
            v = sigma * x;
            if (v > mx * one)
                v = mx * one;
            else if (v < -mx * one)
                v = -mx * one;
            if (v < 0)
                v = -v;
        end else begin
            sigma = ((mx + 1) * 10) / 34;
            v = mx * one + sigma * x;
            if (v > 2 * mx * one)
                v = 2 * mx * one;
            else if (v < 0)
                v = 0;
            if (v > mx * one)
                v = 2 * mx * one - v;
        end
        return 16'(v >>> 20);
    endfunction

    task automatic report_mismatch(input logic [15:0] got, input logic [15:0] want);
        errors++;
        $display("mismatch at %0t: sample %0d, expected %0d", $realtime, got, want);
    endtask

    // driver: advance only after the rising edge took the word
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            word_ch.valid <= 1'b0;
        end else if (!word_ch.valid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                word_ch.valid <= 1'b1;
                word_ch.random_word <= pending_words.pop_front();
            end else begin
                word_ch.valid <= 1'b0;
            end
        end
    end

    // predict at acceptance so config changes between phases stay aligned
    always @(posedge i_clk) begin
        word_taken = i_rst_n && word_ch.valid && word_ch.ready;
        if (word_taken) begin
            expected_samples.push_back(shape_sample(word_ch.random_word));
            words_sent++;
            modes_hit[cur_mode] = 1'b1;
        end
    end

    // receiver ready
    always @(negedge i_clk) begin
        if (!i_rst_n)
            sample_ch.ready <= 1'b0;
        else if (hold_off_cycles > 0) begin
            sample_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else
            sample_ch.ready <= $urandom_range(99, 0) >= recv_idle_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                errors++;
                $display("unexpected sample %0d at %0t", sample_ch.sample, $realtime);
            end else begin
                want = expected_samples.pop_front();
                if (sample_ch.sample !== want)
                    report_mismatch(sample_ch.sample, want);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX)
            cur_max = val;
        else
            cur_mode = val[1:0];
    endtask

    task automatic drain;
        while (pending_words.size() != 0 || word_ch.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (LAT_TOT + 10) @(posedge i_clk);
    endtask

    task automatic load_random(input int count);
        logic [30:0] w;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3, 0))
                0: w = 31'($urandom_range(999999, 0));
                1: w = 31'($urandom_range(20, 0)) * 31'd1000000
                       + 31'($urandom_range(3, 0)) * 31'd500000 + 31'($urandom_range(8, 0))
                       - 31'd4;
                default: w = 31'($urandom);
            endcase
            pending_words.push_back(w);
        end
    endtask

    // max values for the phases, reused in turn; the mode is the phase index mod 4
    logic [15:0] phase_max[10] = '{16'd255, 16'd0, 16'd65535, 16'd1, 16'd1000,
                                   16'd65535, 16'd0, 16'd7, 16'd40000, 16'd255};

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MAX;
        i_cfg_data = '0;
        word_ch.valid = 1'b0;
        word_ch.random_word = '0;
        sample_ch.ready = 1'b0;
        cur_max = 16'd255;
        cur_mode = MODE_UNIFORM;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words in each mode, with max 255 in modes 0 and 2 and 65535 in modes 1 and 3
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_MODE, 16'(m));
            write_reg(CFG_MAX, m[0] ? 16'd65535 : 16'd255);
            pending_words.push_back(31'd0);            // zero probability
            pending_words.push_back(31'h7FFFFFFF);
            pending_words.push_back(31'd500000);       // exact middle
            pending_words.push_back(31'd499999);
            pending_words.push_back(31'd999999);
            pending_words.push_back(31'h2AAAAAAA);
            drain();
        end

        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                send_idle_pct = 12; recv_idle_pct = 88;
            end else if (p < 8) begin
                send_idle_pct = 88; recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            write_reg(CFG_MAX, phase_max[p % 10]);
            write_reg(CFG_MODE, 16'(p % 4));
            if (p == 9)
                hold_off_cycles = 400;   // back up the pipe while words keep coming
            load_random(140);
            drain();
        end

        $display("Checked %0d samples from %0d words; modes seen mask %b.",
                 samples_seen, words_sent, modes_hit);
        $display("Covered zero max, full max, zero probability and long output stall.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
